### rtl/frt_pkg.sv
// Shared types and constants of the fragment reassembly tracker.
package frt_pkg;

   localparam logic [1:0] REQ_FRAGMENT   = 2'd0;
   localparam logic [1:0] REQ_RELIABLE   = 2'd1;
   localparam logic [1:0] REQ_UNRELIABLE = 2'd2;
   localparam logic [1:0] REQ_TICK       = 2'd3;

   localparam logic [1:0] CSR_MAX_PARTS = 2'd0;
   localparam logic [1:0] CSR_MAX_BYTES = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT   = 2'd2;

   localparam logic [16:0] AGE_MAX = 17'h1FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_APPLY,
      ST_AGE,
      ST_EXPIRE,
      ST_SEND
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;      // capture request
      logic lookup;    // register slot search
      logic apply;     // update entries, build result
      logic age;       // age all entries
      logic expire;    // emit lowest-channel expiry
      logic send;      // present result
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic is_tick;
      logic any_hit;   // expiries still pending
      logic last_hit;  // current expiry is the final one
      logic rsp_taken;
   } status_type;

endpackage

### rtl/frt_ctrl.sv
// Sequencing state machine of the fragment reassembly tracker.
module frt_ctrl
   import frt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      tick_more_ff, tick_more_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_more_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_more_ff <= tick_more_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      tick_more_in = tick_more_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = status.is_tick ? ST_AGE : ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply    = 1'b1;
            tick_more_in = 1'b0;
            state_in     = ST_SEND;
         end
         ST_AGE: begin
            cmd.age  = 1'b1;
            state_in = ST_EXPIRE;
         end
         ST_EXPIRE: begin
            if (status.any_hit) begin
               cmd.expire   = 1'b1;
               tick_more_in = !status.last_hit;
               state_in     = ST_SEND;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SEND: begin
            cmd.send = 1'b1;
            if (status.rsp_taken)
               state_in = tick_more_ff ? ST_EXPIRE : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### rtl/frt_datapath.sv
// Entry table, checks and result register of the fragment reassembly tracker.
module frt_datapath
   import frt_pkg::*;
#(
   parameter int MAX_ASSEMBLIES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        csr_valid,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_channel,
   input  logic [31:0] req_packet_id,
   input  logic [15:0] req_part_index,
   input  logic [15:0] req_part_total,
   input  logic [15:0] req_payload_bytes,
   input  logic [15:0] req_delta_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_progressed,
   output logic        rsp_lost_data,
   output logic        rsp_completed,
   output logic [23:0] rsp_assembled_length,
   output logic        rsp_suppressed,
   output logic        rsp_expired,
   output logic [7:0]  rsp_result_channel,
   output logic        rsp_last
);

   localparam int N  = MAX_ASSEMBLIES;
   localparam int SW = (N > 1) ? $clog2(N) : 1;

   // Configuration registers
   logic [15:0] max_parts_ff;
   logic [23:0] max_bytes_ff;
   logic [15:0] timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_parts_ff <= 16'd1024;
         max_bytes_ff <= 24'd1048576;
         timeout_ff   <= 16'd10000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_PARTS: max_parts_ff <= csr_data[15:0];
            CSR_MAX_BYTES: max_bytes_ff <= csr_data;
            CSR_TIMEOUT:   max_parts_ff <= max_parts_ff;
            default:       max_parts_ff <= max_parts_ff;
         endcase
         if (csr_index == CSR_TIMEOUT)
            timeout_ff <= csr_data[15:0];
      end
   end

   // Captured request
   logic [1:0]  type_ff;
   logic [7:0]  ch_ff;
   logic [31:0] id_ff;
   logic [15:0] part_ff, total_ff, bytes_ff, delta_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff  <= req_type;
         ch_ff    <= req_channel;
         id_ff    <= req_packet_id;
         part_ff  <= req_part_index;
         total_ff <= req_part_total;
         bytes_ff <= req_payload_bytes;
         delta_ff <= req_delta_ms;
      end
   end

   // Entry table
   logic [N-1:0] valid_ff;
   logic [7:0]   ech_ff   [N];
   logic [31:0]  eid_ff   [N];
   logic [15:0]  etot_ff  [N];
   logic [15:0]  ecur_ff  [N];
   logic [23:0]  ebyte_ff [N];
   logic [16:0]  eage_ff  [N];
   logic [N-1:0] hit_ff;

   // Slot search, registered
   logic          found_ff, free_ok_ff, bad_ff;
   logic [SW-1:0] found_ix_ff, free_ix_ff;
   logic          found_c, free_c;
   logic [SW-1:0] found_ix_c, free_ix_c;

   always_comb begin
      found_c = 1'b0; found_ix_c = '0;
      free_c  = 1'b0; free_ix_c  = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (valid_ff[i] && ech_ff[i] == ch_ff) begin
            found_c = 1'b1; found_ix_c = SW'(i);
         end
         if (!valid_ff[i]) begin
            free_c = 1'b1; free_ix_c = SW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         found_ff    <= found_c;
         found_ix_ff <= found_ix_c;
         free_ok_ff  <= free_c;
         free_ix_ff  <= free_ix_c;
         bad_ff      <= (total_ff == 16'd0) || (total_ff > max_parts_ff)
                        || (part_ff >= total_ff);
      end
   end

   // Fragment checks on the located entry
   logic        mismatch;
   logic        open_new, cont;
   logic [SW-1:0] slot;
   logic [23:0] base, room;
   logic        overflow;
   logic [23:0] sum;
   logic        done;
   logic [16:0] cur_inc;

   always_comb begin
      cur_inc  = {1'b0, ecur_ff[found_ix_ff]} + 17'd1;
      mismatch = found_ff && (cur_inc != {1'b0, part_ff} ||
                 etot_ff[found_ix_ff] != total_ff || eid_ff[found_ix_ff] != id_ff);
      cont     = found_ff && !mismatch;
      // a mismatched entry frees its slot; lowest free slot then may be it
      open_new = !cont && part_ff == 16'd0 &&
                 (free_ok_ff || mismatch);
      if (cont)
         slot = found_ix_ff;
      else if (mismatch && (!free_ok_ff || found_ix_ff < free_ix_ff))
         slot = found_ix_ff;
      else
         slot = free_ix_ff;
      base     = cont ? ebyte_ff[found_ix_ff] : 24'd0;
      room     = (base <= max_bytes_ff) ? max_bytes_ff - base : 24'd0;
      overflow = {8'd0, bytes_ff} > room;
      sum      = base + {8'd0, bytes_ff};
      done     = ({1'b0, part_ff} + 17'd1) == {1'b0, total_ff};
   end

   // Aging and expiry selection
   logic [N-1:0]  age_hit;
   logic [16:0]   age_new [N];
   logic [SW-1:0] best;
   logic          best_ok;
   logic [N-1:0]  hit_rest;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         logic [17:0] s;
         s = {1'b0, eage_ff[i]} + {2'b0, delta_ff};
         age_new[i] = s[17] ? AGE_MAX : s[16:0];
         age_hit[i] = valid_ff[i] && age_new[i] >= {1'b0, timeout_ff};
      end
      best = '0; best_ok = 1'b0;
      for (int i = 0; i < N; i++) begin
         if (hit_ff[i] && (!best_ok || ech_ff[i] < ech_ff[best])) begin
            best = SW'(i); best_ok = 1'b1;
         end
      end
      hit_rest = hit_ff;
      hit_rest[best] = 1'b0;
   end

   // Table and result updates
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         hit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.send && !rsp_stall)
            rsp_valid_ff <= 1'b0;
         if (cmd.apply) begin
            rsp_valid_ff         <= 1'b1;
            rsp_progressed       <= 1'b0;
            rsp_lost_data        <= 1'b0;
            rsp_completed        <= 1'b0;
            rsp_assembled_length <= '0;
            rsp_suppressed       <= 1'b0;
            rsp_expired          <= 1'b0;
            rsp_result_channel   <= ch_ff;
            rsp_last             <= 1'b1;
            case (type_ff)
               REQ_FRAGMENT: begin
                  if (!bad_ff) begin
                     if (mismatch)
                        valid_ff[found_ix_ff] <= 1'b0;
                     if (!cont && !open_new) begin
                        rsp_lost_data <= 1'b1;
                     end else if (overflow) begin
                        valid_ff[slot] <= 1'b0;
                        rsp_lost_data  <= 1'b1;
                     end else begin
                        valid_ff[slot] <= !done;
                        ech_ff[slot]   <= ch_ff;
                        eid_ff[slot]   <= id_ff;
                        etot_ff[slot]  <= total_ff;
                        ecur_ff[slot]  <= part_ff;
                        ebyte_ff[slot] <= sum;
                        eage_ff[slot]  <= '0;
                        rsp_progressed <= 1'b1;
                        rsp_lost_data  <= mismatch;
                        rsp_completed  <= done;
                        if (done)
                           rsp_assembled_length <= sum;
                     end
                  end
               end
               REQ_RELIABLE: begin
                  if (found_ff) begin
                     valid_ff[found_ix_ff] <= 1'b0;
                     rsp_lost_data         <= 1'b1;
                  end
               end
               default: rsp_suppressed <= found_ff;
            endcase
         end
         if (cmd.age) begin
            for (int i = 0; i < N; i++)
               if (valid_ff[i])
                  eage_ff[i] <= age_new[i];
            hit_ff <= age_hit;
         end
         if (cmd.expire) begin
            hit_ff               <= hit_rest;
            valid_ff[best]       <= 1'b0;
            rsp_valid_ff         <= 1'b1;
            rsp_progressed       <= 1'b0;
            rsp_lost_data        <= 1'b1;
            rsp_completed        <= 1'b0;
            rsp_assembled_length <= '0;
            rsp_suppressed       <= 1'b0;
            rsp_expired          <= 1'b1;
            rsp_result_channel   <= ech_ff[best];
            rsp_last             <= (hit_rest == '0);
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign status.is_tick   = (type_ff == REQ_TICK);
   assign status.any_hit   = (hit_ff != '0);
   assign status.last_hit  = (hit_rest == '0);
   assign status.rsp_taken = rsp_valid_ff && !rsp_stall;

endmodule

### rtl/fragment_reassembly_tracker_top.sv
// Top level of the fragment reassembly tracker.
// Tracks in-order fragment reassembly for up to MAX_ASSEMBLIES channels. One
// item is handled at a time by a small sequencer. A fragment, reliable or
// unreliable item passes through accept, slot search and update, followed by
// its one result transaction; no new item is taken until that result is
// accepted. A tick passes through accept, slot search and aging, then one
// expiry step and one result transaction per expired entry, lowest channel
// first; a tick where nothing expires ends after one expiry check and gives
// no result. The entry table is a set of registers searched in parallel.
// Configuration writes are always ready and should be made idle.
module fragment_reassembly_tracker_top
   import frt_pkg::*;
#(
   parameter int MAX_ASSEMBLIES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_channel,
   input  logic [31:0] req_packet_id,
   input  logic [15:0] req_part_index,
   input  logic [15:0] req_part_total,
   input  logic [15:0] req_payload_bytes,
   input  logic [15:0] req_delta_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_progressed,
   output logic        rsp_lost_data,
   output logic        rsp_completed,
   output logic [23:0] rsp_assembled_length,
   output logic        rsp_suppressed,
   output logic        rsp_expired,
   output logic [7:0]  rsp_result_channel,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   frt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_stall(req_stall), .status(status), .cmd(cmd)
   );

   frt_datapath #(.MAX_ASSEMBLIES(MAX_ASSEMBLIES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .req_type(req_type), .req_channel(req_channel),
      .req_packet_id(req_packet_id), .req_part_index(req_part_index),
      .req_part_total(req_part_total), .req_payload_bytes(req_payload_bytes),
      .req_delta_ms(req_delta_ms),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_progressed(rsp_progressed), .rsp_lost_data(rsp_lost_data),
      .rsp_completed(rsp_completed), .rsp_assembled_length(rsp_assembled_length),
      .rsp_suppressed(rsp_suppressed), .rsp_expired(rsp_expired),
      .rsp_result_channel(rsp_result_channel), .rsp_last(rsp_last)
   );

`ifndef ASSERT_OFF
   // No new transaction while a result is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken with result pending");
   // Completion always carries progress
   a_comp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_completed |-> rsp_progressed && rsp_last)
      else $error("completion without progress");
   // Expiry reports a loss
   a_exp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_expired |-> rsp_lost_data && !rsp_progressed)
      else $error("expiry without loss");
`endif

endmodule
